### hw/rtl/lcce_pkg.sv
// Package for the literal character code entry block.
// Holds field widths, key codes, digit limits and the Unicode mode type.
// No dependencies; compile first.
`default_nettype none

package lcce_pkg;

   localparam int KEY_W   = 8;
   localparam int CODE_W  = 32;
   localparam int COUNT_W = 4;

   // Keys that select the radix or the Unicode digit count, and the bounds of the digit ranges.
   localparam logic [KEY_W-1:0] KEY_HEX_LO  = 8'h78; // x
   localparam logic [KEY_W-1:0] KEY_HEX_UP  = 8'h58; // X
   localparam logic [KEY_W-1:0] KEY_OCT_LO  = 8'h6F; // o
   localparam logic [KEY_W-1:0] KEY_OCT_UP  = 8'h4F; // O
   localparam logic [KEY_W-1:0] KEY_UNI_LO  = 8'h75; // u
   localparam logic [KEY_W-1:0] KEY_UNI_UP  = 8'h55; // U
   localparam logic [KEY_W-1:0] KEY_ZERO    = 8'h30; // 0
   localparam logic [KEY_W-1:0] KEY_SEVEN   = 8'h37; // 7
   localparam logic [KEY_W-1:0] KEY_NINE    = 8'h39; // 9
   localparam logic [KEY_W-1:0] KEY_A_LO    = 8'h61; // a
   localparam logic [KEY_W-1:0] KEY_F_LO    = 8'h66; // f
   localparam logic [KEY_W-1:0] KEY_A_UP    = 8'h41; // A
   localparam logic [KEY_W-1:0] KEY_F_UP    = 8'h46; // F

   localparam logic [CODE_W-1:0] SAT_MAX      = 32'd255;
   localparam logic [CODE_W-1:0] NEWLINE_CODE = 32'd10;

   // Digit limits per mode.
   localparam logic [COUNT_W-1:0] LIMIT_HEX       = 4'd2;
   localparam logic [COUNT_W-1:0] LIMIT_DEC       = 4'd3;
   localparam logic [COUNT_W-1:0] LIMIT_UNI_SHORT = 4'd4;
   localparam logic [COUNT_W-1:0] LIMIT_UNI_LONG  = 4'd8;

   typedef enum logic [1:0] {
      UNI_NONE  = 2'd0,
      UNI_SHORT = 2'd1,
      UNI_LONG  = 2'd2
   } uni_mode_type;

endpackage

`default_nettype wire

### hw/rtl/lcce_req_if.sv
// Keystroke channel of the literal character code entry block.
// Valid/ready handshake with the key payload; depends on lcce_pkg.
`default_nettype none

interface lcce_req_if;
   logic                          valid;
   logic                          ready;
   logic [lcce_pkg::KEY_W-1:0]    key;
   logic                          nul_key;

   modport source (output valid, output key, output nul_key, input ready);
   modport sink   (input valid, input key, input nul_key, output ready);
endinterface

`default_nettype wire

### hw/rtl/lcce_rsp_if.sv
// Result channel of the literal character code entry block.
// Valid/ready handshake with the completion flags and code; depends on lcce_pkg.
`default_nettype none

interface lcce_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          completed;
   logic                          key_rejected;
   logic [lcce_pkg::CODE_W-1:0]   code;

   modport source (output valid, output completed, output key_rejected, output code,
                   input ready);
   modport sink   (input valid, input completed, input key_rejected, input code,
                   output ready);
endinterface

`default_nettype wire

### hw/rtl/literal_char_code_entry.sv
// Literal character code entry: one keystroke in, one result word out per key.
// Every accepted key produces exactly one result word in the next cycle. The decode,
// the radix multiply-add and the limit check sit between the entry state registers
// and a single result register, so a key can be taken every cycle: the block is
// ready whenever the result register is empty or its word is taken in the same
// cycle. Throughput is one key per cycle; only a stalled
// result side holds the block back.
// Depends on lcce_pkg, lcce_req_if and lcce_rsp_if.
`default_nettype none

module literal_char_code_entry (
   input  wire logic  clock,
   input  wire logic  reset,
   lcce_req_if.sink   req_ch,
   lcce_rsp_if.source rsp_ch
);

   localparam int KW = lcce_pkg::KEY_W;
   localparam int CW = lcce_pkg::CODE_W;
   localparam int NW = lcce_pkg::COUNT_W;

   // Entry state.
   logic [CW-1:0]           acc_ff, acc_in;
   logic [NW-1:0]           cnt_ff, cnt_in;
   logic                    hex_ff, hex_in;
   logic                    oct_ff, oct_in;
   lcce_pkg::uni_mode_type  uni_ff, uni_in;

   // Result register.
   logic                    rsp_valid_ff;
   logic                    rsp_completed_ff, rsp_completed_in;
   logic                    rsp_rejected_ff, rsp_rejected_in;
   logic [CW-1:0]           rsp_code_ff, rsp_code_in;

   logic                    accept;
   logic [KW-1:0]           key;
   logic                    is_nul;
   logic                    pfx_hex, pfx_oct, pfx_uni_lo, pfx_uni_up;
   logic [4:0]              hex_digit;
   logic                    digit_ok;
   logic [3:0]              digit;
   logic [CW-1:0]           acc_x10;
   logic                    limit_hit;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign key    = req_ch.key;
   assign is_nul = req_ch.nul_key;

   assign pfx_hex    = !is_nul && (key == lcce_pkg::KEY_HEX_LO || key == lcce_pkg::KEY_HEX_UP);
   assign pfx_oct    = !is_nul && (key == lcce_pkg::KEY_OCT_LO || key == lcce_pkg::KEY_OCT_UP);
   assign pfx_uni_lo = !is_nul && key == lcce_pkg::KEY_UNI_LO;
   assign pfx_uni_up = !is_nul && key == lcce_pkg::KEY_UNI_UP;

   // Hex digit value, with 16 meaning the key is not a hex digit.
   always_comb begin
      if (key >= lcce_pkg::KEY_ZERO && key <= lcce_pkg::KEY_NINE) begin
         hex_digit = {1'b0, 4'(key - lcce_pkg::KEY_ZERO)};
      end else if (key >= lcce_pkg::KEY_A_LO && key <= lcce_pkg::KEY_F_LO) begin
         hex_digit = {1'b0, 4'(key - lcce_pkg::KEY_A_LO + 8'd10)};
      end else if (key >= lcce_pkg::KEY_A_UP && key <= lcce_pkg::KEY_F_UP) begin
         hex_digit = {1'b0, 4'(key - lcce_pkg::KEY_A_UP + 8'd10)};
      end else begin
         hex_digit = 5'd16;
      end
   end

   assign digit = hex_digit[3:0];

   // Hex digits apply when either hex or any Unicode mode is active.
   always_comb begin
      if (is_nul) begin
         digit_ok = 1'b0;
      end else if (hex_ff || uni_ff != lcce_pkg::UNI_NONE) begin
         digit_ok = !hex_digit[4];
      end else if (oct_ff) begin
         digit_ok = key >= lcce_pkg::KEY_ZERO && key <= lcce_pkg::KEY_SEVEN;
      end else begin
         digit_ok = key >= lcce_pkg::KEY_ZERO && key <= lcce_pkg::KEY_NINE;
      end
   end

   assign acc_x10 = {acc_ff[CW-4:0], 3'b000} + {acc_ff[CW-2:0], 1'b0}
                  + {{(CW-4){1'b0}}, digit};

   always_comb begin
      acc_in           = acc_ff;
      cnt_in           = cnt_ff;
      hex_in           = hex_ff;
      oct_in           = oct_ff;
      uni_in           = uni_ff;
      rsp_completed_in = 1'b0;
      rsp_rejected_in  = 1'b0;
      rsp_code_in      = '0;
      limit_hit        = 1'b0;

      if (pfx_hex) begin
         hex_in = 1'b1;
      end else if (pfx_oct) begin
         oct_in = 1'b1;
      end else if (pfx_uni_lo) begin
         uni_in = lcce_pkg::UNI_SHORT;
      end else if (pfx_uni_up) begin
         uni_in = lcce_pkg::UNI_LONG;
      end else if (!digit_ok) begin
         // A non-digit ends the entry and is handed on.
         rsp_completed_in = 1'b1;
         rsp_rejected_in  = 1'b1;
         if (cnt_ff != '0) begin
            rsp_code_in = acc_ff;
         end else if (is_nul) begin
            rsp_code_in = lcce_pkg::NEWLINE_CODE;
         end else begin
            rsp_code_in = {{(CW-KW){1'b0}}, key};
         end
      end else begin
         if (hex_ff || uni_ff != lcce_pkg::UNI_NONE) begin
            acc_in = {acc_ff[CW-5:0], digit};
         end else if (oct_ff) begin
            acc_in = {acc_ff[CW-4:0], digit[2:0]};
         end else begin
            acc_in = acc_x10;
         end
         cnt_in = cnt_ff + 1'b1;
      end

      if (!rsp_completed_in) begin
         if (acc_in > lcce_pkg::SAT_MAX && uni_in == lcce_pkg::UNI_NONE) begin
            acc_in = lcce_pkg::SAT_MAX;
         end
         if (hex_in) begin
            limit_hit = cnt_in >= lcce_pkg::LIMIT_HEX;
         end else if (uni_in == lcce_pkg::UNI_SHORT) begin
            limit_hit = cnt_in >= lcce_pkg::LIMIT_UNI_SHORT;
         end else if (uni_in != lcce_pkg::UNI_NONE) begin
            limit_hit = cnt_in >= lcce_pkg::LIMIT_UNI_LONG;
         end else begin
            limit_hit = cnt_in >= lcce_pkg::LIMIT_DEC;
         end
         if (limit_hit) begin
            rsp_completed_in = 1'b1;
            rsp_code_in      = acc_in;
         end
      end

      if (rsp_completed_in) begin
         acc_in = '0;
         cnt_in = '0;
         hex_in = 1'b0;
         oct_in = 1'b0;
         uni_in = lcce_pkg::UNI_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= '0;
         hex_ff <= 1'b0;
         oct_ff <= 1'b0;
         uni_ff <= lcce_pkg::UNI_NONE;
      end else if (accept) begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
         hex_ff <= hex_in;
         oct_ff <= oct_in;
         uni_ff <= uni_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_completed_ff <= rsp_completed_in;
         rsp_rejected_ff  <= rsp_rejected_in;
         rsp_code_ff      <= rsp_code_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.completed    = rsp_completed_ff;
   assign rsp_ch.key_rejected = rsp_rejected_ff;
   assign rsp_ch.code         = rsp_code_ff;

   // A completed entry leaves no trace in the state.
   a_clear_after_done: assert property (@(posedge clock) disable iff (reset)
      accept && rsp_completed_in |=> acc_ff == '0 && cnt_ff == '0 && !hex_ff && !oct_ff
                                     && uni_ff == lcce_pkg::UNI_NONE)
      else $error("entry state not cleared after completion");

   a_reject_completes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_rejected_ff |-> rsp_completed_ff)
      else $error("rejected key without completion");

   a_code_zero_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_completed_ff |-> rsp_code_ff == '0)
      else $error("nonzero code on an open entry");

   a_saturated: assert property (@(posedge clock) disable iff (reset)
      uni_ff == lcce_pkg::UNI_NONE |-> acc_ff <= lcce_pkg::SAT_MAX)
      else $error("accumulator above saturation outside Unicode mode");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ch.ready)
      else $error("not ready with an empty result register");

endmodule

`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for literal_char_code_entry.
// Depends on lcce_pkg, lcce_req_if, lcce_rsp_if and the block itself. Keystroke
// words drive the block, and each result word is checked against a local predictor.

module testbench;

   localparam int KEY_W   = lcce_pkg::KEY_W;
   localparam int CODE_W  = lcce_pkg::CODE_W;
   localparam int COUNT_W = lcce_pkg::COUNT_W;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic             nul;
   } keystroke_type;

   typedef struct packed {
      logic              completed;
      logic              key_rejected;
      logic [CODE_W-1:0] code;
   } entry_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lcce_req_if req_ch ();
   lcce_rsp_if rsp_ch ();

   literal_char_code_entry u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   keystroke_type    pending_keys[$];
   entry_result_type expected_codes[$];

   // Predictor copy of the entry state.
   logic [CODE_W-1:0]      entry_acc    = '0;
   logic [COUNT_W-1:0]     entry_digits = '0;
   logic                   hex_sel      = 1'b0;
   logic                   oct_sel      = 1'b0;
   lcce_pkg::uni_mode_type uni_sel      = lcce_pkg::UNI_NONE;

   int error_count    = 0;
   int keys_taken     = 0;
   int results_seen   = 0;
   int entries_done   = 0;
   int keys_rejected  = 0;
   int hold_left      = 0;
   bit held_off       = 1'b0;

   // Hex digit value of a key, or 16 when the key is not a hex digit.
   function automatic logic [4:0] hex_digit(input logic [KEY_W-1:0] k);
      if (k >= lcce_pkg::KEY_ZERO && k <= lcce_pkg::KEY_NINE)
         return 5'(k - lcce_pkg::KEY_ZERO);
      if (k >= lcce_pkg::KEY_A_LO && k <= lcce_pkg::KEY_F_LO)
         return 5'(k - lcce_pkg::KEY_A_LO + 10);
      if (k >= lcce_pkg::KEY_A_UP && k <= lcce_pkg::KEY_F_UP)
         return 5'(k - lcce_pkg::KEY_A_UP + 10);
      return 5'd16;
   endfunction

   function automatic entry_result_type predict_code(input keystroke_type ks);
      logic [4:0]        digit;
      logic [4:0]        radix;
      logic              done;
      logic              rejected;
      logic [CODE_W-1:0] code;
      entry_result_type  r;
      done     = 1'b0;
      rejected = 1'b0;
      code     = '0;
      if (!ks.nul && (ks.key == lcce_pkg::KEY_HEX_LO || ks.key == lcce_pkg::KEY_HEX_UP)) begin
         hex_sel = 1'b1;
      end else if (!ks.nul && (ks.key == lcce_pkg::KEY_OCT_LO ||
                               ks.key == lcce_pkg::KEY_OCT_UP)) begin
         oct_sel = 1'b1;
      end else if (!ks.nul && ks.key == lcce_pkg::KEY_UNI_LO) begin
         uni_sel = lcce_pkg::UNI_SHORT;
      end else if (!ks.nul && ks.key == lcce_pkg::KEY_UNI_UP) begin
         uni_sel = lcce_pkg::UNI_LONG;
      end else begin
         digit = 5'd16;
         radix = 5'd10;
         if (!ks.nul) begin
            if (hex_sel || uni_sel != lcce_pkg::UNI_NONE) begin
               radix = 5'd16;
               digit = hex_digit(ks.key);
            end else if (oct_sel) begin
               radix = 5'd8;
               if (ks.key >= lcce_pkg::KEY_ZERO && ks.key <= lcce_pkg::KEY_SEVEN)
                  digit = 5'(ks.key - lcce_pkg::KEY_ZERO);
            end else if (ks.key >= lcce_pkg::KEY_ZERO && ks.key <= lcce_pkg::KEY_NINE) begin
               digit = 5'(ks.key - lcce_pkg::KEY_ZERO);
            end
         end
         if (digit >= radix) begin
            rejected = 1'b1;
            done     = 1'b1;
            if (entry_digits == '0) code = ks.nul ? lcce_pkg::NEWLINE_CODE : CODE_W'(ks.key);
            else code = entry_acc;
         end else begin
            entry_acc    = entry_acc * radix + digit;
            entry_digits = entry_digits + 1'b1;
         end
      end
      // A prefix key can also finish the entry once the new limit is already met.
      if (!done) begin
         if (entry_acc > lcce_pkg::SAT_MAX && uni_sel == lcce_pkg::UNI_NONE)
            entry_acc = lcce_pkg::SAT_MAX;
         if (hex_sel) done = entry_digits >= lcce_pkg::LIMIT_HEX;
         else if (uni_sel == lcce_pkg::UNI_SHORT)
            done = entry_digits >= lcce_pkg::LIMIT_UNI_SHORT;
         else if (uni_sel != lcce_pkg::UNI_NONE)
            done = entry_digits >= lcce_pkg::LIMIT_UNI_LONG;
         else done = entry_digits >= lcce_pkg::LIMIT_DEC;
         if (done) code = entry_acc;
      end
      if (done) begin
         entry_acc    = '0;
         entry_digits = '0;
         hex_sel      = 1'b0;
         oct_sel      = 1'b0;
         uni_sel      = lcce_pkg::UNI_NONE;
      end
      r.completed    = done;
      r.key_rejected = rejected;
      r.code         = done ? code : '0;
      return r;
   endfunction

   // Both sides run without gaps while this window of results passes.
   function automatic bit take_gap();
      if (results_seen >= 500 && results_seen < 650) return 1'b0;
      return $urandom_range(0, 99) < 25;
   endfunction

   always @(posedge clock) begin : drive_keys
      keystroke_type next_key;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (pending_keys.size() != 0 && !take_gap()) begin
            next_key = pending_keys.pop_front();
            req_ch.valid   <= 1'b1;
            req_ch.key     <= next_key.key;
            req_ch.nul_key <= next_key.nul;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // The one long hold-off starts after a few hundred results, while keys keep coming.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (!held_off && results_seen >= 300) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= 60;
         held_off     <= 1'b1;
      end else begin
         rsp_ch.ready <= !take_gap();
      end
   end

   task automatic report_field(input string field, input logic [CODE_W-1:0] want,
                               input logic [CODE_W-1:0] got);
      error_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
   endtask

   // Results are checked before the key taken at the same edge is predicted.
   always @(posedge clock) begin : check_results
      entry_result_type want;
      keystroke_type    taken;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (expected_codes.size() == 0) begin
               error_count++;
               $display("%0t: result word with nothing expected, actual %b %b %h", $time,
                        rsp_ch.completed, rsp_ch.key_rejected, rsp_ch.code);
            end else begin
               want = expected_codes.pop_front();
               if (rsp_ch.completed !== want.completed)
                  report_field("completed", CODE_W'(want.completed),
                               CODE_W'(rsp_ch.completed));
               if (rsp_ch.key_rejected !== want.key_rejected)
                  report_field("key_rejected", CODE_W'(want.key_rejected),
                               CODE_W'(rsp_ch.key_rejected));
               if (rsp_ch.code !== want.code)
                  report_field("code", want.code, rsp_ch.code);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            taken.key = req_ch.key;
            taken.nul = req_ch.nul_key;
            want = predict_code(taken);
            if (want.completed) entries_done++;
            if (want.key_rejected) keys_rejected++;
            expected_codes.push_back(want);
            keys_taken++;
         end
      end
   end

   task automatic push_key(input logic [KEY_W-1:0] k, input logic nul);
      keystroke_type ks;
      ks.key = k;
      ks.nul = nul;
      pending_keys.push_back(ks);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_key(s[i], 1'b0);
   endtask

   // One entry: an optional prefix, digits of its radix up to the limit, then a
   // random key, which need not end the entry, when the limit was not reached.
   task automatic push_entry();
      int               mode;
      int               limit;
      int               count;
      logic [KEY_W-1:0] prefix;
      logic [KEY_W-1:0] digit_key;
      mode  = $urandom_range(0, 6);
      limit = int'(lcce_pkg::LIMIT_DEC);
      case (mode)
         1: begin prefix = lcce_pkg::KEY_HEX_LO; limit = int'(lcce_pkg::LIMIT_HEX); end
         2: begin prefix = lcce_pkg::KEY_HEX_UP; limit = int'(lcce_pkg::LIMIT_HEX); end
         3: prefix = lcce_pkg::KEY_OCT_LO;
         4: prefix = lcce_pkg::KEY_OCT_UP;
         5: begin prefix = lcce_pkg::KEY_UNI_LO; limit = int'(lcce_pkg::LIMIT_UNI_SHORT); end
         6: begin prefix = lcce_pkg::KEY_UNI_UP; limit = int'(lcce_pkg::LIMIT_UNI_LONG); end
         default: prefix = '0;
      endcase
      if (mode != 0) push_key(prefix, 1'b0);
      count = $urandom_range(0, limit);
      for (int i = 0; i < count; i++) begin
         if (mode == 0) begin
            digit_key = lcce_pkg::KEY_ZERO + KEY_W'($urandom_range(0, 9));
         end else if (mode == 3 || mode == 4) begin
            digit_key = lcce_pkg::KEY_ZERO + KEY_W'($urandom_range(0, 7));
         end else begin
            case ($urandom_range(0, 2))
               0:       digit_key = lcce_pkg::KEY_ZERO + KEY_W'($urandom_range(0, 9));
               1:       digit_key = lcce_pkg::KEY_A_LO + KEY_W'($urandom_range(0, 5));
               default: digit_key = lcce_pkg::KEY_A_UP + KEY_W'($urandom_range(0, 5));
            endcase
         end
         push_key(digit_key, 1'b0);
      end
      if (count < limit) push_key(KEY_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
   endtask

   task automatic push_random(input int n);
      int start;
      start = pending_keys.size() + keys_taken;
      while (pending_keys.size() + keys_taken < start + n) begin
         if ($urandom_range(0, 99) < 20)
            push_key(KEY_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
         else
            push_entry();
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_keys.size() != 0 || req_ch.valid || expected_codes.size() != 0);
   endtask

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.key     = '0;
      req_ch.nul_key = 1'b0;
      rsp_ch.ready   = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: NUL alone, extreme keys, saturation, a prefix that ends the
      // entry, octal limit, hex of both cases, NUL after a digit, full Unicode.
      push_key(8'h35, 1'b1);
      push_key(8'h00, 1'b0);
      push_key(8'hFF, 1'b0);
      push_text("999");
      push_text("12x");
      push_text("o8");
      push_text("o777");
      push_text("XfF");
      push_text("7");
      push_key(8'h00, 1'b1);
      push_text("UFFFFFFFF");
      push_random(400);
      wait_drained();
      push_random(400);
      wait_drained();
      repeat (10) @(posedge clock);

      $display("Ran %0d keystrokes: %0d entries completed, %0d keys rejected.",
               keys_taken, entries_done, keys_rejected);
      $display("Decimal, octal, hex and both Unicode forms, with NUL and noise keys.");
      if (error_count == 0 && expected_codes.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("Timed out with %0d results outstanding.", expected_codes.size());
      $display("FAIL");
      $finish;
   end

endmodule
